>>> rtl/core/srrip_pkg.sv
// Shared constants and types for the SRRIP cache lookup unit.
`timescale 1ns / 1ps
package srrip_pkg;
  localparam int WAYS = 4;
  localparam int SETS = 256;
  localparam int WAY_W = 2;
  localparam int SET_W = 8;
  localparam int TAG_W = 32;
  localparam int RRPV_W = 2;
  localparam logic [RRPV_W-1:0] RRPV_MAX = 2'd3;
  localparam logic [3:0] MAX_SET_BITS = 4'd8;

  localparam logic [1:0] REG_OFFSET_BITS = 2'd0;
  localparam logic [1:0] REG_SET_BITS    = 2'd1;
  localparam logic [1:0] REG_ACTIVE_WAYS = 2'd2;
  localparam logic [1:0] REG_INSERT_RRPV = 2'd3;

  // One way of a set as held in the line memory.
  typedef struct packed {
    logic              valid;
    logic              dirty;
    logic [RRPV_W-1:0] rrpv;
    logic [TAG_W-1:0]  tag;
  } line_t;

  typedef line_t [WAYS-1:0] set_line_t;

  // Outcome of one lookup, handed to the counter block.
  typedef struct packed {
    logic             hit;
    logic [WAY_W-1:0] way;
    logic             dirty_ev;
    logic             store;
  } lookup_res_t;
endpackage

>>> rtl/core/srrip_cache_lookup_unit.sv
// Top level: SRRIP set-associative cache tag lookup with statistics.
// Each item first has its set row read from the line memory (a registered read) and is then
// updated and written back in the update state, which also loads the result into the output
// register. An item is taken only in the idle state, so a new item waits until the last one is
// through, and no item is taken while an earlier result waits unread.
// Reset clears control and counters and restores the default configuration; the line
// memory is cleared by a pass over all 256 sets after reset, during which no item is accepted.
`timescale 1ns / 1ps
module srrip_cache_lookup_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // address[31:0]
  input  logic [0:0]  s_tuser,   // is_store[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [167:0] m_tdata   // hit, way_used[2:1], dirty_evicted[3], load_hits,
                                 // store_hits, load_misses, store_misses,
                                 // dirty_evictions, zero fill
);
  import srrip_pkg::*;

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_UPDATE} state_t;

  state_t            state;
  logic [SET_W-1:0]  clr_idx;
  logic [3:0]        offset_bits, set_bits;
  logic [2:0]        active_ways;
  logic [1:0]        insert_rrpv;
  logic [TAG_W-1:0]  tag_q;
  logic [SET_W-1:0]  set_q;
  logic              store_q;
  logic [31:0]       lh, sh, lm, sm, de;
  logic              hit_o, dev_o;
  logic [1:0]        way_o;

  logic [31:0]       addr;
  logic [3:0]        sb;
  logic [2:0]        nways;
  logic [SET_W-1:0]  set_c;
  logic [TAG_W-1:0]  tag_c;
  logic              accept;
  set_line_t         rd_row, new_row, wr_row, clr_row;
  lookup_res_t       res;
  logic              wr_en;
  logic [SET_W-1:0]  wr_addr;

  assign addr = s_tdata;
  assign sb = (set_bits > MAX_SET_BITS) ? MAX_SET_BITS : set_bits;
  assign nways = (active_ways == 3'd0) ? 3'd1 :
                 (active_ways > 3'(WAYS)) ? 3'(WAYS) : active_ways;
  // Index and tag cut from the address.
  always_comb begin
    logic [31:0] sh_a;
    logic [31:0] mask;
    logic [4:0]  tsh;
    sh_a = addr >> offset_bits;
    mask = (32'd1 << sb) - 32'd1;
    set_c = SET_W'(sh_a & mask);
    tsh = 5'(offset_bits) + 5'(sb);
    tag_c = 32'(addr >> tsh);
  end

  assign s_tready = (state == ST_IDLE) && (!m_tvalid || m_tready);
  assign accept = s_tvalid && s_tready;

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      clr_row[w] = '{valid: 1'b0, dirty: 1'b0, rrpv: RRPV_MAX, tag: '0};
    end
  end
  assign wr_en = (state == ST_CLEAR) || (state == ST_UPDATE);
  assign wr_addr = (state == ST_CLEAR) ? clr_idx : set_q;
  assign wr_row = (state == ST_CLEAR) ? clr_row : new_row;

  srrip_set_mem u_mem (
    .clk(clk), .rd_en(accept), .rd_addr(set_c), .rd_data(rd_row),
    .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_row)
  );

  srrip_update u_upd (
    .row_in(rd_row), .tag(tag_q), .store(store_q), .nways(nways),
    .ins_rrpv(insert_rrpv), .row_out(new_row), .res(res)
  );

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == '1) ? v : v + 32'd1;
  endfunction

  // Control, configuration, counters and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_idx <= '0;
      offset_bits <= 4'd6;
      set_bits <= 4'd8;
      active_ways <= 3'd4;
      insert_rrpv <= 2'd2;
      lh <= '0; sh <= '0; lm <= '0; sm <= '0; de <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_OFFSET_BITS: offset_bits <= cfg_data;
          REG_SET_BITS:    set_bits <= cfg_data;
          REG_ACTIVE_WAYS: active_ways <= cfg_data[2:0];
          REG_INSERT_RRPV: insert_rrpv <= cfg_data[1:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == SET_W'(SETS - 1)) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (accept) begin
            tag_q <= tag_c;
            set_q <= set_c;
            store_q <= s_tuser[0];
            state <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          hit_o <= res.hit;
          way_o <= res.way;
          dev_o <= res.dirty_ev;
          if (res.hit) begin
            if (res.store) sh <= sat_inc(sh);
            else lh <= sat_inc(lh);
          end else begin
            if (res.store) sm <= sat_inc(sm);
            else lm <= sat_inc(lm);
            if (res.dirty_ev) de <= sat_inc(de);
          end
          m_tvalid <= 1'b1;
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_tdata = {4'd0, de, sm, lm, sh, lh, dev_o, way_o, hit_o};
endmodule

>>> rtl/core/srrip_set_mem.sv
// Line memory: one row per set, holding all ways; registered read.
`timescale 1ns / 1ps
module srrip_set_mem (
  input  logic                            clk,
  input  logic                            rd_en,
  input  logic [srrip_pkg::SET_W-1:0]     rd_addr,
  output srrip_pkg::set_line_t            rd_data,
  input  logic                            wr_en,
  input  logic [srrip_pkg::SET_W-1:0]     wr_addr,
  input  srrip_pkg::set_line_t            wr_data
);
  import srrip_pkg::*;

  set_line_t mem [SETS];

  // Synchronous write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

>>> rtl/core/srrip_update.sv
// Hit search, SRRIP aging and victim choice for one set row.
`timescale 1ns / 1ps
module srrip_update (
  input  srrip_pkg::set_line_t               row_in,
  input  logic [srrip_pkg::TAG_W-1:0]        tag,
  input  logic                               store,
  input  logic [2:0]                         nways,
  input  logic [srrip_pkg::RRPV_W-1:0]       ins_rrpv,
  output srrip_pkg::set_line_t               row_out,
  output srrip_pkg::lookup_res_t             res
);
  import srrip_pkg::*;

  always_comb begin
    logic              found;
    logic [WAY_W-1:0]  hw;
    logic [RRPV_W-1:0] top;
    logic [RRPV_W-1:0] age;
    logic              vfound;
    logic [WAY_W-1:0]  vw;
    found = 1'b0;
    hw = '0;
    top = '0;
    vfound = 1'b0;
    vw = '0;
    row_out = row_in;
    // First matching valid way among the active ones.
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (3'(w) < nways && row_in[w].valid && row_in[w].tag == tag) begin
        found = 1'b1;
        hw = WAY_W'(w);
      end
    end
    for (int w = 0; w < WAYS; w++) begin
      if (3'(w) < nways && row_in[w].rrpv > top) top = row_in[w].rrpv;
    end
    age = RRPV_MAX - top;
    res.hit = found;
    res.store = store;
    res.dirty_ev = 1'b0;
    if (found) begin
      res.way = hw;
      row_out[hw].rrpv = '0;
      if (store) row_out[hw].dirty = 1'b1;
    end else begin
      // Age the active ways, then replace the first at the maximum.
      for (int w = WAYS - 1; w >= 0; w--) begin
        if (3'(w) < nways) begin
          row_out[w].rrpv = row_in[w].rrpv + age;
          if (row_in[w].rrpv == top) begin
            vfound = 1'b1;
            vw = WAY_W'(w);
          end
        end
      end
      res.way = vfound ? vw : '0;
      res.dirty_ev = row_in[res.way].valid && row_in[res.way].dirty;
      row_out[res.way].tag = tag;
      row_out[res.way].valid = 1'b1;
      row_out[res.way].dirty = 1'b0;
      row_out[res.way].rrpv = ins_rrpv;
    end
  end
endmodule

>>> tb/tb_srrip_cache_lookup_unit.sv
// Testbench for the SRRIP cache lookup unit: directed and random accesses against a predictor.
`timescale 1ns / 1ps
module tb_srrip_cache_lookup_unit;
  import srrip_pkg::*;

  // Expected lookup outcome with the counters after the access.
  typedef struct packed {
    logic [31:0] dirty_evictions;
    logic [31:0] store_misses;
    logic [31:0] load_misses;
    logic [31:0] store_hits;
    logic [31:0] load_hits;
    logic        dirty_evicted;
    logic [1:0]  way_used;
    logic        hit;
  } lookup_out_t;

  // Cache tag predictor and queue of pending lookup outcomes.
  class cache_scoreboard;
    logic [31:0] tags [WAYS*SETS];
    logic [1:0]  rrpv [WAYS*SETS];
    logic        dirty [WAYS*SETS];
    logic        valid [WAYS*SETS];
    logic [31:0] n_ld_hit, n_st_hit, n_ld_miss, n_st_miss, n_dirty_ev;
    logic [3:0]  offset_bits, set_bits;
    logic [2:0]  active_ways;
    logic [1:0]  insert_rrpv;
    lookup_out_t pending[$];
    int          errors;

    function new();
      for (int i = 0; i < WAYS*SETS; i++) begin
        tags[i] = '0;
        rrpv[i] = RRPV_MAX;
        dirty[i] = 1'b0;
        valid[i] = 1'b0;
      end
      n_ld_hit = 0; n_st_hit = 0; n_ld_miss = 0; n_st_miss = 0; n_dirty_ev = 0;
      offset_bits = 4'd6; set_bits = 4'd8; active_ways = 3'd4; insert_rrpv = 2'd2;
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [3:0] val);
      case (idx)
        REG_OFFSET_BITS: offset_bits = val;
        REG_SET_BITS:    set_bits = val;
        REG_ACTIVE_WAYS: active_ways = val[2:0];
        REG_INSERT_RRPV: insert_rrpv = val[1:0];
        default: ;
      endcase
    endfunction

    static function logic [31:0] sat_inc(logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 1;
    endfunction

    // Predict one access and queue its outcome.
    function void note_access(logic [31:0] addr, logic is_store);
      int          sb, nways, base, e, top;
      logic [63:0] set_idx;
      logic [31:0] tag;
      lookup_out_t r;
      sb = (set_bits > MAX_SET_BITS) ? MAX_SET_BITS : set_bits;
      nways = (active_ways < 1) ? 1 : ((active_ways > WAYS) ? WAYS : active_ways);
      set_idx = ({32'd0, addr} >> offset_bits) & ((64'd1 << sb) - 1);
      tag = 32'(({32'd0, addr} >> (offset_bits + sb)));
      base = int'(set_idx) * WAYS;
      r = '0;
      for (int w = 0; w < nways; w++) begin
        if (!r.hit && valid[base+w] && tags[base+w] == tag) begin
          r.hit = 1'b1;
          r.way_used = w[1:0];
          rrpv[base+w] = 2'd0;
          if (is_store) dirty[base+w] = 1'b1;
        end
      end
      if (r.hit) begin
        if (is_store) n_st_hit = sat_inc(n_st_hit);
        else n_ld_hit = sat_inc(n_ld_hit);
      end else begin
        // Age the set until some way reaches the distant interval.
        top = 0;
        for (int w = 0; w < nways; w++)
          if (rrpv[base+w] > top) top = rrpv[base+w];
        for (int w = 0; w < nways; w++) rrpv[base+w] = rrpv[base+w] + 2'(3 - top);
        e = -1;
        for (int w = 0; w < nways; w++)
          if (e < 0 && rrpv[base+w] == RRPV_MAX) e = w;
        r.way_used = e[1:0];
        e = base + e;
        if (valid[e] && dirty[e]) begin
          r.dirty_evicted = 1'b1;
          n_dirty_ev = sat_inc(n_dirty_ev);
        end
        tags[e] = tag;
        valid[e] = 1'b1;
        dirty[e] = 1'b0;
        rrpv[e] = insert_rrpv;
        if (is_store) n_st_miss = sat_inc(n_st_miss);
        else n_ld_miss = sat_inc(n_ld_miss);
      end
      r.load_hits = n_ld_hit;
      r.store_hits = n_st_hit;
      r.load_misses = n_ld_miss;
      r.store_misses = n_st_miss;
      r.dirty_evictions = n_dirty_ev;
      pending.push_back(r);
    endfunction

    function void check_result(logic [167:0] data);
      lookup_out_t got, exp_r;
      got = data[163:0];
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $realtime, got);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.hit !== exp_r.hit)
        $display("%0t: hit expected %0d actual %0d", $realtime, exp_r.hit, got.hit);
      if (got.way_used !== exp_r.way_used)
        $display("%0t: way_used expected %0d actual %0d", $realtime,
                 exp_r.way_used, got.way_used);
      if (got.dirty_evicted !== exp_r.dirty_evicted)
        $display("%0t: dirty_evicted expected %0d actual %0d", $realtime,
                 exp_r.dirty_evicted, got.dirty_evicted);
      if (got.load_hits !== exp_r.load_hits)
        $display("%0t: load_hits expected %0d actual %0d", $realtime,
                 exp_r.load_hits, got.load_hits);
      if (got.store_hits !== exp_r.store_hits)
        $display("%0t: store_hits expected %0d actual %0d", $realtime,
                 exp_r.store_hits, got.store_hits);
      if (got.load_misses !== exp_r.load_misses)
        $display("%0t: load_misses expected %0d actual %0d", $realtime,
                 exp_r.load_misses, got.load_misses);
      if (got.store_misses !== exp_r.store_misses)
        $display("%0t: store_misses expected %0d actual %0d", $realtime,
                 exp_r.store_misses, got.store_misses);
      if (got.dirty_evictions !== exp_r.dirty_evictions)
        $display("%0t: dirty_evictions expected %0d actual %0d", $realtime,
                 exp_r.dirty_evictions, got.dirty_evictions);
      if (got !== exp_r || data[167:164] !== 4'd0) errors++;
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_index = '0;
  logic [3:0]   cfg_data = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [31:0]  s_tdata = '0;   // address[31:0]
  logic [0:0]   s_tuser = '0;   // is_store[0]
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [167:0] m_tdata;        // hit, way_used, dirty_evicted, five counters, zero fill

  cache_scoreboard sb = new();
  logic        no_idle = 1'b0;
  logic [31:0] hot_addrs [12];

  srrip_cache_lookup_unit u_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #5 clk = ~clk;

  // Receiver: random stalls, results checked at the rising edge.
  always @(negedge clk) m_tready <= no_idle || ($urandom_range(0, 99) >= 28);
  always @(posedge clk) if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);

  task automatic write_reg(logic [1:0] idx, logic [3:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  // Present one access and hold it until it is accepted.
  task automatic send_access(logic [31:0] addr, logic is_store);
    while (!no_idle && $urandom_range(0, 99) < 28) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= addr;
    s_tuser <= is_store;
    do @(posedge clk); while (!s_tready);
    sb.note_access(addr, is_store);
    @(negedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_config(logic [3:0] off, logic [3:0] sbits, logic [2:0] ways,
                            logic [1:0] ins);
    write_reg(REG_OFFSET_BITS, off);
    write_reg(REG_SET_BITS, sbits);
    write_reg(REG_ACTIVE_WAYS, {1'b0, ways});
    write_reg(REG_INSERT_RRPV, {2'b00, ins});
  endtask

  // Random accesses, mostly to a few conflicting lines so that sets fill and evict.
  task automatic random_phase(int count);
    int          sh;
    logic [31:0] a;
    sh = sb.offset_bits + ((sb.set_bits > MAX_SET_BITS) ? MAX_SET_BITS : sb.set_bits);
    for (int i = 0; i < 12; i++)
      hot_addrs[i] = 32'((64'($urandom_range(0, 5)) << sh) |
                         (64'($urandom_range(0, 2)) << sb.offset_bits));
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 80)
        a = hot_addrs[$urandom_range(0, 11)] |
            (32'($urandom) & 32'((64'd1 << sb.offset_bits) - 1));
      else
        a = $urandom;
      send_access(a, 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: extremes, store hit then dirty eviction from a full set.
    set_config(4'd6, 4'd8, 3'd4, 2'd2);
    send_access(32'h0000_0000, 1'b0);
    send_access(32'hFFFF_FFFF, 1'b1);
    send_access(32'hFFFF_FFFF, 1'b0);
    send_access(32'h0000_0000, 1'b1);
    send_access(32'h0000_003F, 1'b1);
    for (int t = 1; t <= 6; t++) send_access(32'(t) << 14, t[0]);
    send_access(32'h0000_0000, 1'b0);
    send_access(32'hAAAA_AAAA, 1'b1);
    send_access(32'h5555_5555, 1'b0);
    send_access(32'hAAAA_AAAA, 1'b0);
    drain();

    set_config(4'd6, 4'd8, 3'd4, 2'd2);
    random_phase(190);
    drain();
    set_config(4'd0, 4'd0, 3'd1, 2'd0);
    random_phase(150);
    drain();
    no_idle = 1'b1;
    set_config(4'd12, 4'd8, 3'd4, 2'd3);
    random_phase(200);
    drain();
    no_idle = 1'b0;
    set_config(4'd15, 4'd15, 3'd7, 2'd1);
    random_phase(190);
    drain();
    set_config(4'd4, 4'd2, 3'd0, 2'd3);
    random_phase(180);
    drain();
    set_config(4'd3, 4'd4, 3'd2, 2'd0);
    random_phase(190);
    drain();
    set_config(4'd9, 4'd1, 3'd3, 2'd2);
    random_phase(190);
    drain();
    set_config(4'd0, 4'd8, 3'd4, 2'd0);
    random_phase(200);
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end
endmodule

>>> files.f
rtl/core/srrip_pkg.sv
rtl/core/srrip_set_mem.sv
rtl/core/srrip_update.sv
rtl/core/srrip_cache_lookup_unit.sv
tb/tb_srrip_cache_lookup_unit.sv
